[design/decision_tree_classifier_core_defines.svh]
// Assertion macros used by the decision tree classifier core.
`ifndef DECISION_TREE_CLASSIFIER_CORE_DEFINES_SVH
`define DECISION_TREE_CLASSIFIER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a consequence in the same cycle as its cause.
`define DTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check a consequence in the cycle after its cause.
`define DTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DTC_ASSERT_SAME(label, ante, cons, msg)
`define DTC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[design/dtc_pkg.sv]
// Field widths and action codes of the decision tree classifier.
`timescale 1ns / 1ps

package dtc_pkg;

    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 9;
    localparam int POSITION_W = 6;
    localparam int FIELD_W    = 16;
    localparam int CLASS_W    = 2;

    typedef logic [ACTION_W-1:0] t_action;

    localparam t_action ACT_NODE = 2'd0;
    localparam t_action ACT_POST = 2'd1;
    localparam t_action ACT_FEAT = 2'd2;

endpackage

[design/decision_tree_classifier_core.sv]
// Top level of the decision tree classifier: tree, posterior and sample stores plus walker.
`timescale 1ns / 1ps
`include "decision_tree_classifier_core_defines.svh"

// Channel   Direction  Handshake             Moves
// input     in         i_valid / o_stall     one node, posterior or feature write
// output    out        o_valid / i_stall     one class posterior of the reached node
//
// Node, posterior and non-final feature transfers are taken whenever o_stall is low.
// A final feature starts a walk: per internal node, S_FEAT takes the node word and reads
// the sample, S_CMP compares and fetches the child; a leaf mark or the deepest level stops
// it. Per class, S_PRD reads the posterior RAM and S_PLD loads the output register. The
// walk is bound by the node RAM then sample RAM read chain. After reset a clearing pass
// zeroes the posteriors and sets every leaf mark; o_stall stays high meanwhile.
// A stalled output holds the next posterior read; the last result may wait while new
// input transfers are taken.

module decision_tree_classifier_core
    import dtc_pkg::*;
#(
    parameter int TREE_DEPTH = 8,
    parameter int N_CLASSES  = 4,
    parameter int N_FEATURES = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  t_action                      i_action,
    input  logic [INDEX_W-1:0]           i_node_index,
    input  logic [POSITION_W-1:0]        i_split_feature,
    input  logic signed [FIELD_W-1:0]    i_threshold,
    input  logic                         i_leaf_flag,
    input  logic [CLASS_W-1:0]           i_class_index,
    input  logic [FIELD_W-1:0]           i_posterior_value,
    input  logic [POSITION_W-1:0]        i_feature_position,
    input  logic signed [FIELD_W-1:0]    i_feature_value,
    input  logic                         i_last_feature,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [CLASS_W-1:0]           o_class_out,
    output logic [FIELD_W-1:0]           o_posterior_out,
    output logic [INDEX_W-1:0]           o_leaf_reached,
    output logic                         o_last_class
);

    // Derived sizes
    localparam int VAL_W      = (VALUE_BITS < 16) ? VALUE_BITS : 16;
    localparam int NW         = TREE_DEPTH + 1;
    localparam int NODE_COUNT = (1 << NW) - 1;
    localparam int CW         = $clog2(N_CLASSES);
    localparam int PAW        = NW + CW;
    localparam int PDEPTH     = NODE_COUNT << CW;
    localparam int FAW        = (N_FEATURES > 1) ? $clog2(N_FEATURES) : 1;
    localparam int IXW        = (NW > INDEX_W) ? NW : INDEX_W;
    localparam int CXW        = (CW > CLASS_W) ? CW : CLASS_W;
    localparam int FPW        = (FAW > POSITION_W) ? FAW : POSITION_W;
    localparam int LXW        = (NW > INDEX_W) ? NW : INDEX_W;

    localparam logic [NW-1:0]      FIRST_DEEP = NW'((1 << TREE_DEPTH) - 1);
    localparam logic [PAW-1:0]     CLR_LAST   = PAW'(PDEPTH - 1);
    localparam logic [CW-1:0]      CLS_LAST   = CW'(N_CLASSES - 1);
    localparam logic [CLASS_W-1:0] CLS_LAST_O = CLASS_W'(N_CLASSES - 1);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FEAT  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_PRD   = 3'd4;
    localparam logic [2:0] S_PLD   = 3'd5;

    typedef struct packed {
        logic                    leaf;
        logic [POSITION_W-1:0]   feat;
        logic signed [VAL_W-1:0] thr;
    } t_node;

    localparam int NDW = $bits(t_node);

    // Registers
    logic [2:0]              r_state, n_state;
    logic [PAW-1:0]          r_clr, n_clr;
    logic [NW-1:0]           r_node, n_node;
    logic [CW-1:0]           r_cls, n_cls;
    logic signed [VAL_W-1:0] r_thr, n_thr;
    logic                    r_oor, n_oor;
    logic                    r_o_valid, n_o_valid;
    logic [CLASS_W-1:0]      r_o_class;
    logic [FIELD_W-1:0]      r_o_post;
    logic [INDEX_W-1:0]      r_o_leaf;
    logic                    r_o_last;

    // Memory ports
    logic              node_we, node_re;
    logic [NW-1:0]     node_waddr, node_raddr;
    t_node             node_wdata, node_rd;
    logic [NDW-1:0]    node_rdata;

    logic              post_we, post_re;
    logic [PAW-1:0]    post_waddr;
    logic [FIELD_W-1:0] post_wdata, post_rdata;

    logic              feat_we, feat_re;
    logic [FAW-1:0]    feat_waddr, feat_raddr;
    logic [VAL_W-1:0]  feat_rdata;

    // Input decode
    logic              accept;
    logic [IXW-1:0]    idx_x;
    logic [CXW-1:0]    cls_x;
    logic [FPW-1:0]    fpos_x;
    logic [FPW-1:0]    sf_x;
    logic              idx_ok, cls_ok, fpos_ok, sf_ok;
    logic              start;

    // Walk datapath
    logic signed [VAL_W-1:0] x_val;
    logic                    go_right;
    logic [NW-1:0]           child;
    logic [CXW-1:0]          ocls_x;
    logic [LXW-1:0]          leaf_x;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    assign idx_x   = IXW'(i_node_index);
    assign cls_x   = CXW'(i_class_index);
    assign fpos_x  = FPW'(i_feature_position);
    assign idx_ok  = (32'(i_node_index) < NODE_COUNT);
    assign cls_ok  = (32'(i_class_index) < N_CLASSES);
    assign fpos_ok = (32'(i_feature_position) < N_FEATURES);
    assign start   = accept && (i_action == ACT_FEAT) && i_last_feature;

    assign node_rd = t_node'(node_rdata);
    assign sf_x    = FPW'(node_rd.feat);
    assign sf_ok   = (32'(node_rd.feat) < N_FEATURES);

    // Positions beyond the sample compare against zero
    assign x_val    = r_oor ? '0 : $signed(feat_rdata);
    assign go_right = (x_val > r_thr);
    assign child    = {r_node[NW-2:0], 1'b0} + (go_right ? NW'(2) : NW'(1));

    // Store writes: clearing pass after reset, item writes when idle
    always_comb begin
        node_we    = 1'b0;
        node_waddr = idx_x[NW-1:0];
        node_wdata = '{leaf: i_leaf_flag, feat: i_split_feature,
                       thr: $signed(i_threshold[VAL_W-1:0])};
        post_we    = 1'b0;
        post_waddr = {idx_x[NW-1:0], cls_x[CW-1:0]};
        post_wdata = i_posterior_value;
        feat_we    = 1'b0;
        feat_waddr = fpos_x[FAW-1:0];
        if (r_state == S_CLEAR) begin
            node_we    = 1'b1;
            node_waddr = r_clr[PAW-1:CW];
            node_wdata = '{leaf: 1'b1, feat: '0, thr: '0};
            post_we    = 1'b1;
            post_waddr = r_clr;
            post_wdata = '0;
        end else if (accept) begin
            case (i_action)
                ACT_NODE: begin
                    node_we = idx_ok;
                end
                ACT_POST: begin
                    post_we = idx_ok && cls_ok;
                end
                ACT_FEAT: begin
                    feat_we = fpos_ok;
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_node     = r_node;
        n_cls      = r_cls;
        n_thr      = r_thr;
        n_oor      = r_oor;
        node_re    = 1'b0;
        node_raddr = '0;
        feat_re    = 1'b0;
        feat_raddr = sf_x[FAW-1:0];
        post_re    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // The root always sits above the deepest level: fetch it at once
                if (start) begin
                    node_re = 1'b1;
                    n_node  = '0;
                    n_cls   = '0;
                    n_state = S_FEAT;
                end
            end
            S_FEAT: begin
                if (node_rd.leaf) begin
                    n_state = S_PRD;
                end else begin
                    feat_re = 1'b1;
                    n_thr   = node_rd.thr;
                    n_oor   = !sf_ok;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_node = child;
                if (child >= FIRST_DEEP) begin
                    n_state = S_PRD;
                end else begin
                    node_re    = 1'b1;
                    node_raddr = child;
                    n_state    = S_FEAT;
                end
            end
            S_PRD: begin
                // Issue the read only when the output register is free next cycle
                if (!r_o_valid || !i_stall) begin
                    post_re = 1'b1;
                    n_state = S_PLD;
                end
            end
            S_PLD: begin
                if (r_cls == CLS_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_cls   = r_cls + 1'b1;
                    n_state = S_PRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (r_state == S_PLD) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
        end
    end

    assign ocls_x = CXW'(r_cls);
    assign leaf_x = LXW'(r_node);

    // Walk and result payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_cls  <= n_cls;
        r_thr  <= n_thr;
        r_oor  <= n_oor;
        if (r_state == S_PLD) begin
            r_o_class <= ocls_x[CLASS_W-1:0];
            r_o_post  <= post_rdata;
            r_o_leaf  <= leaf_x[INDEX_W-1:0];
            r_o_last  <= (r_cls == CLS_LAST);
        end
    end

    assign o_valid         = r_o_valid;
    assign o_class_out     = r_o_class;
    assign o_posterior_out = r_o_post;
    assign o_leaf_reached  = r_o_leaf;
    assign o_last_class    = r_o_last;

    // Node store: split feature, threshold and leaf mark per heap index
    dtc_ram #(
        .WIDTH (NDW),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    // Posterior store: one row of classes per node
    dtc_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (PDEPTH)
    ) u_post_ram (
        .i_clk   (i_clk),
        .i_we    (post_we),
        .i_waddr (post_waddr),
        .i_wdata (post_wdata),
        .i_re    (post_re),
        .i_raddr ({r_node, r_cls}),
        .o_rdata (post_rdata)
    );

    // Sample buffer
    dtc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (N_FEATURES)
    ) u_feat_ram (
        .i_clk   (i_clk),
        .i_we    (feat_we),
        .i_waddr (feat_waddr),
        .i_wdata (i_feature_value[VAL_W-1:0]),
        .i_re    (feat_re),
        .i_raddr (feat_raddr),
        .o_rdata (feat_rdata)
    );

    `DTC_ASSERT_SAME(a_load_into_free, r_state == S_PLD, !r_o_valid, "output register overwritten")
    `DTC_ASSERT_NEXT(a_load_shows, r_state == S_PLD, o_valid, "loaded result not presented")
    `DTC_ASSERT_SAME(a_walk_above_deep, r_state == S_FEAT, r_node < FIRST_DEEP,
                     "walk past deepest level")
    `DTC_ASSERT_SAME(a_cmp_after_fetch, r_state == S_CMP, $past(r_state) == S_FEAT,
                     "compare without sample fetch")
    `DTC_ASSERT_SAME(a_last_class_id, o_valid && o_last_class, o_class_out == CLS_LAST_O,
                     "last marker on wrong class")

endmodule

[design/dtc_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module dtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_re,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic             i_re;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[dv/tb_decision_tree_classifier_core.sv]
// Testbench for decision_tree_classifier_core: directed and random traffic against a tree model.
`timescale 1ns / 1ps

module tb_decision_tree_classifier_core
    import dtc_pkg::*;
();

    localparam int TREE_DEPTH = 8;
    localparam int N_CLASSES  = 4;
    localparam int N_FEATURES = 64;
    localparam int VALUE_BITS = 16;

    localparam int NODE_COUNT = (1 << (TREE_DEPTH + 1)) - 1;
    localparam int FIRST_DEEP = (1 << TREE_DEPTH) - 1;

    // The spare action code; the block drops it.
    localparam t_action ACT_NONE = 2'd3;

    // Random traffic stops once this many items other than the spare code have been accepted.
    localparam int ITEM_TARGET   = 430;
    localparam int PAUSE_AT      = 240;
    localparam int TAIL_CYCLES   = 40;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    typedef struct {
        t_action                    act;
        logic [INDEX_W-1:0]         node_index;
        logic [POSITION_W-1:0]      split_feature;
        logic signed [FIELD_W-1:0]  threshold;
        logic                       leaf_flag;
        logic [CLASS_W-1:0]         class_index;
        logic [FIELD_W-1:0]         posterior_value;
        logic [POSITION_W-1:0]      feature_position;
        logic signed [FIELD_W-1:0]  feature_value;
        logic                       last_feature;
    } t_tree_item;

    typedef struct {
        logic [CLASS_W-1:0] class_out;
        logic [FIELD_W-1:0] posterior_out;
        logic [INDEX_W-1:0] leaf_reached;
        logic               last_class;
    } t_class_result;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // ------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------
    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    t_action                    i_action;
    logic [INDEX_W-1:0]         i_node_index;
    logic [POSITION_W-1:0]      i_split_feature;
    logic signed [FIELD_W-1:0]  i_threshold;
    logic                       i_leaf_flag;
    logic [CLASS_W-1:0]         i_class_index;
    logic [FIELD_W-1:0]         i_posterior_value;
    logic [POSITION_W-1:0]      i_feature_position;
    logic signed [FIELD_W-1:0]  i_feature_value;
    logic                       i_last_feature;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [CLASS_W-1:0]         o_class_out;
    logic [FIELD_W-1:0]         o_posterior_out;
    logic [INDEX_W-1:0]         o_leaf_reached;
    logic                       o_last_class;

    always #2 i_clk = ~i_clk;

    decision_tree_classifier_core #(
        .TREE_DEPTH (TREE_DEPTH),
        .N_CLASSES  (N_CLASSES),
        .N_FEATURES (N_FEATURES),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_node_index       (i_node_index),
        .i_split_feature    (i_split_feature),
        .i_threshold        (i_threshold),
        .i_leaf_flag        (i_leaf_flag),
        .i_class_index      (i_class_index),
        .i_posterior_value  (i_posterior_value),
        .i_feature_position (i_feature_position),
        .i_feature_value    (i_feature_value),
        .i_last_feature     (i_last_feature),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_class_out        (o_class_out),
        .o_posterior_out    (o_posterior_out),
        .o_leaf_reached     (o_leaf_reached),
        .o_last_class       (o_last_class)
    );

    // ------------------------------------------------------------------
    // Local copy of the tree, the posteriors and the sample buffer
    // ------------------------------------------------------------------
    logic [POSITION_W-1:0]      tree_split  [NODE_COUNT];
    logic signed [FIELD_W-1:0]  tree_thresh [NODE_COUNT];
    logic                       tree_leaf   [NODE_COUNT];
    logic [FIELD_W-1:0]         tree_post   [NODE_COUNT][N_CLASSES];
    logic signed [FIELD_W-1:0]  sample_buf  [N_FEATURES];

    // Posteriors still owed by the block, oldest first.
    t_class_result pending_posteriors[$];

    int error_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;

    initial begin
        for (int n = 0; n < NODE_COUNT; n++) begin
            tree_split[n]  = '0;
            tree_thresh[n] = '0;
            tree_leaf[n]   = 1'b1;
            for (int c = 0; c < N_CLASSES; c++)
                tree_post[n][c] = '0;
        end
        for (int p = 0; p < N_FEATURES; p++)
            sample_buf[p] = '0;
    end

    // Walk from the root: right on a strictly greater feature, left otherwise,
    // stopping at a leaf mark or on the deepest level.
    function automatic int unsigned walk_to_leaf();
        int unsigned n;
        n = 0;
        while (n < FIRST_DEEP && !tree_leaf[n]) begin
            if (sample_buf[tree_split[n]] > tree_thresh[n])
                n = 2 * n + 2;
            else
                n = 2 * n + 1;
        end
        return n;
    endfunction

    // Update the local copy with one accepted transfer and queue its results.
    function automatic void absorb_item(t_tree_item it);
        int unsigned   leaf;
        t_class_result r;
        case (it.act)
            ACT_NODE: begin
                if (it.node_index < NODE_COUNT) begin
                    tree_split[it.node_index]  = it.split_feature;
                    tree_thresh[it.node_index] = it.threshold;
                    tree_leaf[it.node_index]   = it.leaf_flag;
                end
            end
            ACT_POST: begin
                if (it.node_index < NODE_COUNT && it.class_index < N_CLASSES)
                    tree_post[it.node_index][it.class_index] = it.posterior_value;
            end
            ACT_FEAT: begin
                if (it.feature_position < N_FEATURES)
                    sample_buf[it.feature_position] = it.feature_value;
                if (it.last_feature) begin
                    leaf = walk_to_leaf();
                    for (int c = 0; c < N_CLASSES; c++) begin
                        r.class_out     = CLASS_W'(c);
                        r.posterior_out = tree_post[leaf][c];
                        r.leaf_reached  = INDEX_W'(leaf);
                        r.last_class    = (c == N_CLASSES - 1);
                        pending_posteriors.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item builders: every field random, then the ones that matter set
    // ------------------------------------------------------------------
    function automatic t_tree_item rand_item();
        t_tree_item  it;
        logic [31:0] a, b, c;
        a = $urandom;
        b = $urandom;
        c = $urandom;
        it.act              = t_action'(a[1:0]);
        it.node_index       = a[10:2];
        it.split_feature    = a[16:11];
        it.leaf_flag        = a[17];
        it.class_index      = a[19:18];
        it.feature_position = a[25:20];
        it.last_feature     = a[26];
        it.threshold        = b[15:0];
        it.posterior_value  = b[31:16];
        it.feature_value    = c[15:0];
        return it;
    endfunction

    function automatic t_tree_item node_item(int unsigned idx, int unsigned feat,
                                             logic signed [FIELD_W-1:0] thr, logic leaf);
        t_tree_item it;
        it               = rand_item();
        it.act           = ACT_NODE;
        it.node_index    = INDEX_W'(idx);
        it.split_feature = POSITION_W'(feat);
        it.threshold     = thr;
        it.leaf_flag     = leaf;
        return it;
    endfunction

    function automatic t_tree_item post_item(int unsigned idx, int unsigned cls,
                                             logic [FIELD_W-1:0] value);
        t_tree_item it;
        it                 = rand_item();
        it.act             = ACT_POST;
        it.node_index      = INDEX_W'(idx);
        it.class_index     = CLASS_W'(cls);
        it.posterior_value = value;
        return it;
    endfunction

    function automatic t_tree_item feat_item(int unsigned pos,
                                             logic signed [FIELD_W-1:0] value, logic last);
        t_tree_item it;
        it                  = rand_item();
        it.act              = ACT_FEAT;
        it.feature_position = POSITION_W'(pos);
        it.feature_value    = value;
        it.last_feature     = last;
        return it;
    endfunction

    // Q8.8 value with the extremes and zero drawn more often than chance.
    function automatic logic signed [FIELD_W-1:0] pick_value();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return raw[15:0];
        endcase
    endfunction

    // Mostly a node on a random level, now and then any index or the one past the end.
    function automatic int unsigned pick_node();
        int unsigned lvl;
        case ($urandom_range(0, 19))
            0:       return NODE_COUNT;
            1, 2:    return $urandom_range(0, (1 << INDEX_W) - 1);
            default: begin
                lvl = $urandom_range(0, TREE_DEPTH);
                return (1 << lvl) - 1 + $urandom_range(0, (1 << lvl) - 1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transfer per call, with bursts and gaps
    // ------------------------------------------------------------------
    task automatic send_item(t_tree_item it);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            // Drop valid for a random gap, then start a fresh burst; a long burst
            // now and then gives stretches with no idling at all.
            i_valid = 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 20);
        end
        i_action           = it.act;
        i_node_index       = it.node_index;
        i_split_feature    = it.split_feature;
        i_threshold        = it.threshold;
        i_leaf_flag        = it.leaf_flag;
        i_class_index      = it.class_index;
        i_posterior_value  = it.posterior_value;
        i_feature_position = it.feature_position;
        i_feature_value    = it.feature_value;
        i_last_feature     = it.last_feature;
        i_valid            = 1'b1;
        // Hold the payload until the block takes it.
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        burst_left--;
        if (it.act != ACT_NONE)
            items_sent++;
        absorb_item(it);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_posteriors.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern changes mode after a random run of cycles
    // ------------------------------------------------------------------
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_run  = 0;
    int unsigned stall_tick = 0;

    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_run  = $urandom_range(8, 64);
        end
        stall_run--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_HALF:  i_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= (stall_tick % 3 == 0);
        endcase
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_class_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_posteriors.size() == 0) begin
                $error("result transfer with nothing expected: class %0d leaf %0d",
                       o_class_out, o_leaf_reached);
                error_count++;
            end else begin
                want = pending_posteriors.pop_front();
                if (o_class_out !== want.class_out) begin
                    $error("class_out mismatch: expected %0d, got %0d",
                           want.class_out, o_class_out);
                    error_count++;
                end
                if (o_posterior_out !== want.posterior_out) begin
                    $error("posterior_out mismatch: expected %04h, got %04h",
                           want.posterior_out, o_posterior_out);
                    error_count++;
                end
                if (o_leaf_reached !== want.leaf_reached) begin
                    $error("leaf_reached mismatch: expected %0d, got %0d",
                           want.leaf_reached, o_leaf_reached);
                    error_count++;
                end
                if (o_last_class !== want.last_class) begin
                    $error("last_class mismatch: expected %0b, got %0b",
                           want.last_class, o_last_class);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset every node is a leaf with zero posteriors, so a
    // classification stops at the root. Also drop a spare action code and a
    // node write past the end of the tree.
    task automatic test_reset_state();
        t_tree_item it;
        it     = rand_item();
        it.act = ACT_NONE;
        send_item(it);
        send_item(node_item(NODE_COUNT, 63, 16'sh1234, 1'b0));
        send_item(feat_item(5, 16'sh8000, 1'b1));
    endtask

    // Load the root posteriors with extremes; a write past the end is dropped.
    task automatic test_posterior_load();
        send_item(post_item(0, 0, 16'h0000));
        send_item(post_item(0, 1, 16'hFFFF));
        send_item(post_item(0, 2, 16'h8000));
        send_item(post_item(0, 3, 16'h0001));
        send_item(post_item(NODE_COUNT, 3, 16'h1234));
        send_item(feat_item(63, 16'sh7FFF, 1'b1));
    endtask

    // Root splits on the top position: equal goes left, greater goes right,
    // and the compare is signed.
    task automatic test_split_compare();
        send_item(node_item(0, 63, 16'sh7FFF, 1'b0));
        send_item(post_item(1, 0, 16'h1111));
        send_item(post_item(2, 1, 16'h2222));
        send_item(feat_item(63, 16'sh7FFF, 1'b1));
        send_item(node_item(0, 63, 16'sh8000, 1'b0));
        send_item(feat_item(63, 16'sh8000, 1'b1));
        send_item(feat_item(63, 16'sh8001, 1'b1));
        send_item(node_item(0, 63, -16'sd1, 1'b0));
        send_item(feat_item(63, 16'sd1, 1'b1));
    endtask

    // A left-hand chain of internal nodes down to the deepest level; the node
    // there has its leaf mark clear and must still end the walk.
    task automatic test_deepest_level();
        int unsigned n;
        n = FIRST_DEEP;
        while (n > 0) begin
            send_item(node_item(n, 0, 16'sh7FFF, 1'b0));
            n = (n - 1) / 2;
        end
        send_item(node_item(0, 0, 16'sh7FFF, 1'b0));
        send_item(post_item(FIRST_DEEP, 2, 16'hABCD));
        send_item(feat_item(0, 16'sh0000, 1'b1));
    endtask

    // Write every sample position so later walks never read an unwritten one.
    task automatic test_sample_fill();
        for (int p = 0; p < N_FEATURES; p++)
            send_item(feat_item(p, pick_value(), p == N_FEATURES - 1));
    endtask

    // Write a branch from the root towards the deepest level whose thresholds
    // follow the current sample, load the end node's posteriors, then classify.
    task automatic grow_branch();
        t_tree_item  it;
        int unsigned n;
        int unsigned feat;
        int unsigned k;
        n = 0;
        for (int lvl = 0; lvl <= TREE_DEPTH; lvl++) begin
            feat = $urandom_range(0, N_FEATURES - 1);
            it   = node_item(n, feat, sample_buf[feat], $urandom_range(0, 11) == 0);
            if ($urandom_range(0, 4) == 0)
                it.threshold = pick_value();
            else if ($urandom_range(0, 1) == 1 && sample_buf[feat] != 16'sh8000)
                it.threshold = sample_buf[feat] - 16'sd1;
            send_item(it);
            if (it.leaf_flag || lvl == TREE_DEPTH)
                break;
            n = (sample_buf[feat] > it.threshold) ? 2 * n + 2 : 2 * n + 1;
        end
        for (int c = 0; c < N_CLASSES; c++)
            send_item(post_item(n, c, pick_value()));
        k = $urandom_range(1, 4);
        for (int j = 1; j <= k; j++)
            send_item(feat_item($urandom_range(0, N_FEATURES - 1), pick_value(), j == k));
    endtask

    // Mixed traffic: well-formed branches plus loose writes and noise.
    task automatic test_random_traffic(int target);
        t_tree_item  it;
        int unsigned r;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                grow_branch();
            end else begin
                it = rand_item();
                r  = $urandom_range(0, 99);
                if (r < 25) begin
                    it.act        = ACT_NODE;
                    it.node_index = INDEX_W'(pick_node());
                    it.leaf_flag  = ($urandom_range(0, 3) == 0);
                end else if (r < 45) begin
                    it.act        = ACT_POST;
                    it.node_index = INDEX_W'(pick_node());
                end else if (r < 95) begin
                    it.act           = ACT_FEAT;
                    it.feature_value = pick_value();
                    it.last_feature  = ($urandom_range(0, 3) == 0);
                end else begin
                    it.act = ACT_NONE;
                end
                send_item(it);
            end
        end
    endtask

    // Hold off the input until every owed result has come out.
    task automatic test_drain_pause();
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_action           = ACT_NODE;
        i_node_index       = '0;
        i_split_feature    = '0;
        i_threshold        = '0;
        i_leaf_flag        = 1'b0;
        i_class_index      = '0;
        i_posterior_value  = '0;
        i_feature_position = '0;
        i_feature_value    = '0;
        i_last_feature     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_posterior_load();
        test_split_compare();
        test_deepest_level();
        test_sample_fill();
        test_random_traffic(PAUSE_AT);
        test_drain_pause();
        test_random_traffic(ITEM_TARGET);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Covers the clearing pass after reset and the slowest legal run many times over.
    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[decision_tree_classifier_core.f]
+incdir+design
design/dtc_pkg.sv
design/dtc_ram.sv
design/decision_tree_classifier_core.sv
dv/tb_decision_tree_classifier_core.sv
